// ===== sv/generational_handle_allocator_unit_defines.svh =====
// Assertion macros used by the checker file ghalloc_checker.sv.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define GHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ghalloc_pkg.sv =====
package ghalloc_pkg;

  localparam int ENTRIES  = 1024;
  localparam int IDX_W    = 10;
  localparam int CYC_W    = 16;
  localparam int TABLES   = 64;
  localparam int TAB_W    = 7;
  localparam int CNT_W    = 11;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 120;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_ATTACH = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_ACTIVE = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_BAD_TABLE  = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX  = 3'd4;
  localparam logic [2:0] ST_BAD_GEN    = 3'd5;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd6;

  typedef struct packed {
    logic clear;   // clearing pass, one row per cycle
    logic load;    // item accepted, issue reads
    logic commit;  // apply updates and load output register
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_hold;
  } sts_t;

endpackage

// ===== sv/generational_handle_allocator_unit.sv =====
// Generational handle allocator.
// Input stream s_*: one operation per item (allocate, free, query, attach).
// Output stream m_*: exactly one result item per input item, in order.
// Config channel cfg_*: writes table_count; always ready, write only while idle.
// An accepted item first gets registered memory reads of the entry, active
// list and free stack; the update then commits and loads the result into the
// output register, which sets m_tvalid. No new item is taken until it commits.
// A new item is taken while the previous result still waits in the output
// register; if the receiver stalls, the next item holds in its update cycle
// and s_tready stays low until the output register frees up.
// Reset: a clearing pass rewrites all 1024 rows of the entry table and the
// free stack, one row per cycle; s_tready stays low during the pass.
// Free stack starts with indices 1023 down to 1, generation 1, index 1 on top.
module generational_handle_allocator_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [1:0] op, [11:2] handle_index, [27:12] handle_cycle, [34:28] table_number
  input  logic [39:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [2:0] status, [12:3] out_index, [28:13] out_cycle, [92:29] notify_mask,
  // [102:93] active_count, [112:103] free_count
  output logic [119:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data
);

  ghalloc_pkg::cmd_t cmd;
  ghalloc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ghalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ghalloc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== sv/ghalloc_ctrl.sv =====
module ghalloc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  ghalloc_pkg::sts_t  sts,
  output ghalloc_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready   = (state == S_IDLE);
  assign cmd.clear  = (state == S_CLEAR);
  assign cmd.load   = s_tvalid && s_tready;
  assign cmd.commit = (state == S_EXEC) && !sts.out_hold;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clear_last) state_next = S_IDLE;
      S_IDLE:  if (cmd.load) state_next = S_EXEC;
      S_EXEC:  if (!sts.out_hold) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/ghalloc_dp.sv =====
module ghalloc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  ghalloc_pkg::cmd_t                cmd,
  output ghalloc_pkg::sts_t                sts,
  input  logic [ghalloc_pkg::IN_W-1:0]     s_tdata,
  input  logic                             cfg_valid,
  input  logic [ghalloc_pkg::TAB_W-1:0]    cfg_data,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ghalloc_pkg::OUT_W-1:0]    m_tdata
);

  localparam int IW = ghalloc_pkg::IDX_W;
  localparam int CW = ghalloc_pkg::CYC_W;
  localparam int NW = ghalloc_pkg::CNT_W;
  localparam int TW = ghalloc_pkg::TAB_W;
  localparam int EN = ghalloc_pkg::ENTRIES;

  // storage
  logic [CW:0]    meta_mem  [EN];   // {retired, cycle}
  logic [63:0]    tab_mem   [EN];
  logic [IW-1:0]  slot_mem  [EN];
  logic [IW-1:0]  list_mem  [EN];
  logic [CW+IW-1:0] stack_mem [EN]; // {cycle, index}

  logic [IW-1:0] clr_addr;
  logic [TW-1:0] table_count;
  logic [NW-1:0] free_top, free_top_next;
  logic [NW-1:0] total, total_next;

  // latched item and read data
  logic [1:0]      op_q;
  logic [IW-1:0]   idx_q;
  logic [CW-1:0]   cyc_q;
  logic [TW-1:0]   tab_q;
  logic [CW:0]     meta_rd;
  logic [63:0]     tab_rd;
  logic [IW-1:0]   slot_rd;
  logic [IW-1:0]   last_rd;
  logic [CW+IW-1:0] stk_rd;

  logic [IW-1:0] in_idx;
  logic [NW-1:0] top_m1, total_m1;
  logic [CW-1:0] next_cyc;
  logic [63:0]   live_mask, src_bit, tab_set;
  logic          active, alloc_ok, free_ok, attach_ok, push, tab_bad;
  logic [2:0]    status;
  logic [IW-1:0] oidx;
  logic [CW-1:0] ocyc;
  logic [63:0]   notify;

  assign in_idx   = s_tdata[11:2];
  assign top_m1   = free_top - NW'(1);
  assign total_m1 = total - NW'(1);

  assign sts.clear_last = (clr_addr == IW'(EN - 1));
  assign sts.out_hold   = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      table_count <= '0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + IW'(1);
      if (cfg_valid) table_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= s_tdata[1:0];
      idx_q   <= in_idx;
      cyc_q   <= s_tdata[27:12];
      tab_q   <= s_tdata[34:28];
      meta_rd <= meta_mem[in_idx];
      tab_rd  <= tab_mem[in_idx];
      slot_rd <= slot_mem[in_idx];
      last_rd <= list_mem[total_m1[IW-1:0]];
      stk_rd  <= stack_mem[top_m1[IW-1:0]];
    end
  end

  always_comb begin
    active    = (idx_q != '0) && !meta_rd[CW] && (meta_rd[CW-1:0] == cyc_q);
    alloc_ok  = (op_q == ghalloc_pkg::OP_ALLOC) && (free_top != '0) && (total < NW'(EN));
    free_ok   = (op_q == ghalloc_pkg::OP_FREE) && active && (total != '0);
    next_cyc  = meta_rd[CW-1:0] + CW'(1);
    push      = free_ok && (next_cyc != '0) && (free_top < NW'(EN));
    tab_bad   = (tab_q >= table_count) || (tab_q >= TW'(ghalloc_pkg::TABLES));
    // index is 10 bits wide, so it is always below the entry count
    attach_ok = (op_q == ghalloc_pkg::OP_ATTACH) && !tab_bad && (meta_rd[CW-1:0] == cyc_q);
    live_mask = (table_count >= TW'(64)) ? '1 : ((64'(1) << table_count[5:0]) - 64'(1));
    src_bit   = (tab_q < TW'(64)) ? (64'(1) << tab_q[5:0]) : '0;
    tab_set   = tab_rd | (64'(1) << tab_q[5:0]);
    notify    = free_ok ? (tab_rd & live_mask & ~src_bit) : '0;

    free_top_next = free_top;
    total_next    = total;
    if (alloc_ok) begin
      free_top_next = top_m1;
      total_next    = total + NW'(1);
    end
    if (free_ok) total_next = total_m1;
    if (push) free_top_next = free_top + NW'(1);

    oidx = alloc_ok ? stk_rd[IW-1:0] : idx_q;
    ocyc = alloc_ok ? stk_rd[CW+IW-1:IW] : cyc_q;

    status = ghalloc_pkg::ST_OK;
    unique case (op_q)
      ghalloc_pkg::OP_ALLOC:  if (!alloc_ok) status = ghalloc_pkg::ST_EMPTY;
      ghalloc_pkg::OP_FREE: begin
        if (!free_ok) status = ghalloc_pkg::ST_NOT_ACTIVE;
        else if (next_cyc == '0) status = ghalloc_pkg::ST_EXHAUSTED;
      end
      ghalloc_pkg::OP_QUERY:  if (!active) status = ghalloc_pkg::ST_NOT_ACTIVE;
      ghalloc_pkg::OP_ATTACH: begin
        if (tab_bad) status = ghalloc_pkg::ST_BAD_TABLE;
        else if (meta_rd[CW-1:0] != cyc_q) status = ghalloc_pkg::ST_BAD_GEN;
      end
      default: status = ghalloc_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top <= NW'(EN - 1);
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        free_top <= free_top_next;
        total    <= total_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {7'd0, free_top_next[IW-1:0], total_next[IW-1:0], notify, ocyc, oidx, status};
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      meta_mem[clr_addr] <= {1'b1, CW'(0)};
    end else if (cmd.commit && alloc_ok) begin
      meta_mem[stk_rd[IW-1:0]] <= {1'b0, stk_rd[CW+IW-1:IW]};
    end else if (cmd.commit && free_ok) begin
      meta_mem[idx_q] <= {1'b1, meta_rd[CW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      tab_mem[clr_addr] <= '0;
    end else if (cmd.commit && free_ok) begin
      tab_mem[idx_q] <= '0;
    end else if (cmd.commit && attach_ok) begin
      tab_mem[idx_q] <= tab_set;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && alloc_ok) begin
      slot_mem[stk_rd[IW-1:0]] <= total[IW-1:0];
    end else if (cmd.commit && free_ok) begin
      slot_mem[last_rd] <= slot_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && alloc_ok) begin
      list_mem[total[IW-1:0]] <= stk_rd[IW-1:0];
    end else if (cmd.commit && free_ok) begin
      list_mem[slot_rd] <= last_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      stack_mem[clr_addr] <= {CW'(1), IW'(EN - 1) - clr_addr};
    end else if (cmd.commit && push) begin
      stack_mem[free_top[IW-1:0]] <= {next_cyc, idx_q};
    end
  end

endmodule

// ===== sv/ghalloc_checker.sv =====
`include "generational_handle_allocator_unit_defines.svh"

module ghalloc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [119:0] m_tdata
);

  // held result stays put
  `GHA_ASSERT_NEXT(a_out_hold, clk, rst, !rst && m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")
  // one item at a time
  `GHA_ASSERT_NEXT(a_one_item, clk, rst, !rst && s_tvalid && s_tready, !s_tready, "accepted two items back to back")
  // empty-stack status only when the stack is really empty
  `GHA_ASSERT_NOW(a_empty, clk, rst, m_tvalid && (m_tdata[2:0] == ghalloc_pkg::ST_EMPTY), m_tdata[112:103] == 10'd0, "stack empty reported with free handles")
  // notifications only come from a successful free
  `GHA_ASSERT_NOW(a_notify, clk, rst, m_tvalid && (m_tdata[92:29] != 64'd0), (m_tdata[2:0] == ghalloc_pkg::ST_OK) || (m_tdata[2:0] == ghalloc_pkg::ST_EXHAUSTED), "notify mask on a failed step")

endmodule

bind generational_handle_allocator_unit ghalloc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
